FILE: hdl/mal_pkg.sv
// ----------------------------------------------------------------------------
// mal_pkg
// Types, codes and constants shared by the MRU address list block.
// ----------------------------------------------------------------------------
package mal_pkg;

  localparam int DEFAULT_LIST_DEPTH = 8;
  localparam int MAC_W    = 48;
  localparam int NAME_W   = 64;
  localparam int INDEX_W  = 8;
  localparam int HIT_W    = 6;
  localparam int WINDOW_W = 7;

  localparam logic [WINDOW_W-1:0] ADD_WINDOW_RESET = 7'd8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FORGET = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_MISS    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [MAC_W-1:0]   mac_addr;
    logic [NAME_W-1:0]  name_value;
    logic [INDEX_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              hit;
    logic [HIT_W-1:0]  hit_index;
    logic [MAC_W-1:0]  read_mac;
    logic [NAME_W-1:0] read_name;
    logic              changed;
  } rsp_t;

  typedef logic [WINDOW_W-1:0] cfg_t;

  typedef struct packed {
    logic load_req;
    logic compare;
    logic apply;
  } ctrl_cmd_t;

endpackage

FILE: hdl/mal_stream_if.sv
// ----------------------------------------------------------------------------
// mal_stream_if
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
interface mal_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/mru_address_list.sv
// ----------------------------------------------------------------------------
// mru_address_list
// Most-recently-used list of address/name entries with add, forget, remove
// and read requests.
// ----------------------------------------------------------------------------
// Flow: an accepted request passes a parallel compare across the cells and
//   then a shift/update step, after which the result is offered.
// Overlap: a new request is taken in the update state (or while idle),
//   stalled only while the previous result has not been taken.
// Reset: all entries cleared to zero, add_window set to 8, no result pending.
// The configuration channel is always ready.
module mru_address_list
  import mal_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mal_stream_if.sink   req_i,
  mal_stream_if.source rsp_o,
  mal_stream_if.sink   cfg_i
);

  ctrl_cmd_t cmd;
  rsp_t      rsp_data;

  assign cfg_i.ready = 1'b1;

  mal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  mal_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i.data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .rsp_o      (rsp_data)
  );

  assign rsp_o.data = rsp_data;

endmodule

FILE: hdl/mal_ctrl.sv
// ----------------------------------------------------------------------------
// mal_ctrl
// Sequencer: request capture, parallel compare, shift/update and output hold.
// ----------------------------------------------------------------------------
module mal_ctrl
  import mal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_apply;
  logic   req_ready;

  // result slot frees up in the same cycle it is taken
  assign can_apply = !out_valid_q || rsp_ready_i;

  always_comb begin
    req_ready = 1'b0;
    case (state_q)
      S_IDLE:   req_ready = 1'b1;
      S_UPDATE: req_ready = can_apply;
      default:  req_ready = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_COMPARE;
      end
      S_COMPARE: state_d = S_UPDATE;
      S_UPDATE: begin
        if (can_apply) state_d = req_valid_i ? S_COMPARE : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.load_req = req_valid_i && req_ready;
    cmd_o.compare  = (state_q == S_COMPARE);
    cmd_o.apply    = (state_q == S_UPDATE) && can_apply;
    req_ready_o    = req_ready;
    rsp_valid_o    = out_valid_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply)      out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_apply_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> (!out_valid_q || rsp_ready_i))
    else $error("update applied while result slot still occupied");

  a_apply_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> rsp_valid_o)
    else $error("result not presented after update");

  a_compare_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> cmd_o.compare)
    else $error("compare did not follow request capture");

  a_no_load_in_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.compare |-> !cmd_o.load_req && !cmd_o.apply)
    else $error("request taken or update applied during compare");

endmodule

FILE: hdl/mal_datapath.sv
// ----------------------------------------------------------------------------
// mal_datapath
// Entry cells, parallel address compare, shift network and result register.
// ----------------------------------------------------------------------------
module mal_datapath
  import mal_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  req_t      req_i,
  input  logic      cfg_we_i,
  input  cfg_t      cfg_data_i,
  output rsp_t      rsp_o
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int WW = $clog2(LIST_DEPTH + 1);
  localparam logic [WINDOW_W-1:0] WIN_MAX   = WINDOW_W'(LIST_DEPTH);
  localparam logic [INDEX_W-1:0]  IDX_LIMIT = INDEX_W'(LIST_DEPTH);

  cfg_t              add_window_q;
  req_t              req_q;
  logic [MAC_W-1:0]  addr_q  [LIST_DEPTH];
  logic [NAME_W-1:0] label_q [LIST_DEPTH];
  logic [MAC_W-1:0]  addr_d  [LIST_DEPTH];
  logic [NAME_W-1:0] label_d [LIST_DEPTH];

  logic          found_q, found_c;
  logic [IW-1:0] found_idx_q, found_idx_c;
  logic [IW-1:0] evict_q;
  logic [WW-1:0] win_c;
  logic [WINDOW_W-1:0] win_clamp;
  logic [LIST_DEPTH-1:0] match;

  rsp_t rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_window_q <= ADD_WINDOW_RESET;
    end else if (cfg_we_i) begin
      add_window_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  // window clamped to 1..LIST_DEPTH
  always_comb begin
    win_clamp = add_window_q;
    if (add_window_q == '0)          win_clamp = WINDOW_W'(1);
    else if (add_window_q > WIN_MAX) win_clamp = WIN_MAX;
    win_c = WW'(win_clamp);
  end

  // compare all cells in parallel; forget searches the whole list
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match[i] = (addr_q[i] == req_q.mac_addr) &&
                 ((req_q.operation == OP_FORGET) || (WW'(i) < win_c));
    end
  end

  always_comb begin
    found_c     = 1'b0;
    found_idx_c = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_c     = 1'b1;
        found_idx_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      found_q     <= found_c;
      found_idx_q <= found_idx_c;
      evict_q     <= IW'(win_c - WW'(1));
    end
  end

  // update stage
  logic              addr_ok, idx_ok, add_go, del_go;
  logic [IW-1:0]     idx_pos, ins_pos, del_pos;
  logic [NAME_W-1:0] kept_name, new_name;

  always_comb begin
    addr_ok   = (req_q.mac_addr != '0) && (req_q.mac_addr != '1);
    idx_ok    = req_q.entry_index < IDX_LIMIT;
    idx_pos   = req_q.entry_index[IW-1:0];
    add_go    = (req_q.operation == OP_ADD) && addr_ok;
    del_go    = ((req_q.operation == OP_FORGET) && found_q) ||
                ((req_q.operation == OP_REMOVE) && idx_ok);
    ins_pos   = found_q ? found_idx_q : evict_q;
    del_pos   = (req_q.operation == OP_FORGET) ? found_idx_q : idx_pos;
    kept_name = found_q ? label_q[found_idx_q] : '0;
    new_name  = (req_q.name_value != '0) ? req_q.name_value : kept_name;

    for (int i = 0; i < LIST_DEPTH; i++) begin
      addr_d[i]  = addr_q[i];
      label_d[i] = label_q[i];
      if (add_go) begin
        if (i == 0) begin
          addr_d[i]  = req_q.mac_addr;
          label_d[i] = new_name;
        end else if (IW'(i) <= ins_pos) begin
          addr_d[i]  = addr_q[(i > 0) ? i - 1 : 0];
          label_d[i] = label_q[(i > 0) ? i - 1 : 0];
        end
      end else if (del_go && (IW'(i) >= del_pos)) begin
        if (i == LIST_DEPTH - 1) begin
          addr_d[i]  = '0;
          label_d[i] = '0;
        end else begin
          addr_d[i]  = addr_q[(i < LIST_DEPTH - 1) ? i + 1 : i];
          label_d[i] = label_q[(i < LIST_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        addr_q[i]  <= '0;
        label_q[i] <= '0;
      end
    end else if (cmd_i.apply) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        addr_q[i]  <= addr_d[i];
        label_q[i] <= label_d[i];
      end
    end
  end

  always_comb begin
    rsp_d           = '0;
    rsp_d.changed   = add_go || del_go;
    case (req_q.operation)
      OP_ADD: begin
        rsp_d.status = addr_ok ? ST_DONE : ST_INVALID;
        rsp_d.hit    = addr_ok && found_q;
      end
      OP_FORGET: begin
        rsp_d.status = found_q ? ST_DONE : ST_MISS;
        rsp_d.hit    = found_q;
      end
      OP_REMOVE: begin
        rsp_d.status = idx_ok ? ST_DONE : ST_MISS;
      end
      OP_READ: begin
        rsp_d.status = idx_ok ? ST_DONE : ST_MISS;
        if (idx_ok) begin
          rsp_d.read_mac  = addr_q[idx_pos];
          rsp_d.read_name = label_q[idx_pos];
        end
      end
      default: rsp_d.status = ST_MISS;
    endcase
    rsp_d.hit_index = rsp_d.hit ? HIT_W'(found_idx_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  a_reject_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && (req_q.operation == OP_ADD) && !addr_ok) |=>
      (!rsp_q.changed && !rsp_q.hit && (rsp_q.status == ST_INVALID)))
    else $error("rejected address reported as a change or hit");

  a_add_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && add_go) |=> (addr_q[0] == $past(req_q.mac_addr)))
    else $error("added address not at the front");

  a_hit_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && !rsp_d.hit) |=> (rsp_q.hit_index == '0))
    else $error("hit index set without a hit");

endmodule
